// File: design/kli_pkg.sv
// Package: keyframe ROMs, microcode program and shared types for the lighting interpolator.
package kli_pkg;

   localparam int KEYFRAME_COUNT = 8;
   localparam int COMPONENT_BITS = 16;
   localparam int ROM_DEPTH      = 16;
   localparam int ROM_IDX_BITS   = $clog2(ROM_DEPTH);
   localparam int CHANNELS       = 16;
   localparam int CHAN_IDX_BITS  = $clog2(CHANNELS);
   localparam int DIV_STEPS      = 16;
   localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS);

   localparam logic [20:0] HOURS_24    = 21'd1572864;
   localparam logic [20:0] TIME_RESET  = 21'd786432;
   localparam logic [15:0] SPEED_RESET = 16'd3277;

   localparam logic [ROM_IDX_BITS-1:0] LAST_KEY = ROM_IDX_BITS'(KEYFRAME_COUNT - 1);

   // keyframe hours, Q5.16
   localparam logic [20:0] KF_HOUR [ROM_DEPTH] = '{
      0: 21'd0,       1: 21'd327680,  2: 21'd425984,  3: 21'd786432,
      4: 21'd1146880, 5: 21'd1245184, 6: 21'd1343488, 7: 21'd1572864,
      default: 21'd0
   };

   // zenith rgb, horizon rgb, light rgb, position xyz, ambient, tint rgb (Q2.14)
   localparam logic signed [15:0] KF_VAL [ROM_DEPTH][CHANNELS] = '{
      0: '{16'sd246, 16'sd246, 16'sd819, 16'sd328, 16'sd328, 16'sd1311, 16'sd3277,
           16'sd3277, 16'sd5734, 16'sd0, -16'sd16384, 16'sd0, 16'sd1966, 16'sd983,
           16'sd1311, 16'sd3604},
      1: '{16'sd246, 16'sd246, 16'sd819, 16'sd328, 16'sd328, 16'sd1311, 16'sd3277,
           16'sd3277, 16'sd5734, 16'sd0, -16'sd16384, 16'sd0, 16'sd1966, 16'sd983,
           16'sd1311, 16'sd3604},
      2: '{16'sd1638, 16'sd2458, 16'sd5734, 16'sd13926, 16'sd7373, 16'sd4096,
           16'sd13107, 16'sd8192, 16'sd5734, 16'sd16384, 16'sd3277, 16'sd0, 16'sd2458,
           16'sd14746, 16'sd10650, 16'sd8192},
      3: '{16'sd1966, 16'sd5243, 16'sd11796, 16'sd9011, 16'sd11796, 16'sd15073,
           16'sd16384, 16'sd16384, 16'sd15565, 16'sd3277, 16'sd16384, 16'sd3277,
           16'sd3604, 16'sd16384, 16'sd16384, 16'sd16384},
      4: '{16'sd1966, 16'sd5243, 16'sd11796, 16'sd9011, 16'sd11796, 16'sd15073,
           16'sd16384, 16'sd16384, 16'sd15565, 16'sd3277, 16'sd16384, 16'sd3277,
           16'sd3604, 16'sd16384, 16'sd16384, 16'sd16384},
      5: '{16'sd1311, 16'sd1311, 16'sd4096, 16'sd14418, 16'sd4588, 16'sd1966,
           16'sd13926, 16'sd5734, 16'sd2458, -16'sd16384, 16'sd2458, 16'sd0, 16'sd2458,
           16'sd15565, 16'sd8192, 16'sd4915},
      6: '{16'sd492, 16'sd492, 16'sd1966, 16'sd1311, 16'sd983, 16'sd2949, 16'sd4915,
           16'sd4096, 16'sd6554, -16'sd16384, -16'sd3277, 16'sd0, 16'sd2294, 16'sd3277,
           16'sd3277, 16'sd6554},
      7: '{16'sd246, 16'sd246, 16'sd819, 16'sd328, 16'sd328, 16'sd1311, 16'sd3277,
           16'sd3277, 16'sd5734, 16'sd0, -16'sd16384, 16'sd0, 16'sd1966, 16'sd983,
           16'sd1311, 16'sd3604},
      default: '{default: 16'sd0}
   };

   // sequencer steps
   typedef enum logic [3:0] {
      STEP_IDLE,
      STEP_MUL,
      STEP_ACC,
      STEP_SEG,
      STEP_DIV_INIT,
      STEP_DIV,
      STEP_T_FIX,
      STEP_LERP_MUL,
      STEP_LERP_ADD,
      STEP_OUT
   } step_type;

   typedef enum logic [3:0] {
      OP_LOAD,
      OP_MUL,
      OP_ACC,
      OP_SEG,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_T_FIX,
      OP_LERP_MUL,
      OP_LERP_ADD,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_NO_REQ,
      COND_DIV_MORE,
      COND_CHAN_MORE,
      COND_OUT_BUSY
   } cond_type;

   // branch taken -> branch, else -> next
   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type branch;
      step_type next;
   } ctrl_word_type;

   function automatic ctrl_word_type micro_word(step_type step);
      ctrl_word_type w;
      case (step)
         STEP_IDLE:     w = '{OP_LOAD,      COND_NO_REQ,    STEP_IDLE,     STEP_MUL};
         STEP_MUL:      w = '{OP_MUL,       COND_NEVER,     STEP_IDLE,     STEP_ACC};
         STEP_ACC:      w = '{OP_ACC,       COND_NEVER,     STEP_IDLE,     STEP_SEG};
         STEP_SEG:      w = '{OP_SEG,       COND_NEVER,     STEP_IDLE,     STEP_DIV_INIT};
         STEP_DIV_INIT: w = '{OP_DIV_INIT,  COND_NEVER,     STEP_IDLE,     STEP_DIV};
         STEP_DIV:      w = '{OP_DIV_STEP,  COND_DIV_MORE,  STEP_DIV,      STEP_T_FIX};
         STEP_T_FIX:    w = '{OP_T_FIX,     COND_NEVER,     STEP_IDLE,     STEP_LERP_MUL};
         STEP_LERP_MUL: w = '{OP_LERP_MUL,  COND_NEVER,     STEP_IDLE,     STEP_LERP_ADD};
         STEP_LERP_ADD: w = '{OP_LERP_ADD,  COND_CHAN_MORE, STEP_LERP_MUL, STEP_OUT};
         STEP_OUT:      w = '{OP_EMIT,      COND_OUT_BUSY,  STEP_OUT,      STEP_IDLE};
         default:       w = '{OP_LOAD,      COND_NEVER,     STEP_IDLE,     STEP_IDLE};
      endcase
      return w;
   endfunction

   // top COMPONENT_BITS of each Q2.14 value, first component in the top bits
   function automatic logic [47:0] pack3(logic [15:0] c0, logic [15:0] c1, logic [15:0] c2);
      logic [47:0] r;
      r = '0;
      r[3*COMPONENT_BITS-1 -: COMPONENT_BITS] = c0[15 -: COMPONENT_BITS];
      r[2*COMPONENT_BITS-1 -: COMPONENT_BITS] = c1[15 -: COMPONENT_BITS];
      r[COMPONENT_BITS-1   -: COMPONENT_BITS] = c2[15 -: COMPONENT_BITS];
      return r;
   endfunction

endpackage

// File: design/keyframe_lighting_interpolator.sv
// Top level: time-of-day accumulator and keyframe lighting interpolator, microcoded.
//
// Each request carries an elapsed time (Q4.16 s). The block advances its time of
// day by elapsed_time * day_speed (Q5.16 h, wrapped at 24 h), picks the keyframe
// segment that holds the new time, and linearly interpolates the 16 lighting
// channels between the two keyframes. A small microcode program in a read-only
// table sequences one shared datapath: a step counter, a control word per step,
// and conditional branches for the loops. From acceptance to the result
// register, a request passes through the elapsed-time multiply, the
// accumulate/wrap and the segment search, the restoring divider that forms
// the Q1.16 blend factor (an init step, then one quotient bit a cycle), a step
// to settle it, the 16 channels through the lerp multiplier shared by all
// channels (multiply, then add, per channel), and a step to load the result.
// The sequencer is back in its first step the cycle after; a new request is
// taken only in that first step, not while the program runs. The next request
// is taken once the result register holds the previous one; a result left
// waiting on rsp_ready holds the sequencer in its last step.
// day_speed is written through csr_wr_en/csr_wr_data with no wait and resets
// to 3277 (0.05 h/s); the time of day resets to twelve hours.
module keyframe_lighting_interpolator (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [19:0] req_elapsed_time,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [20:0] rsp_hour_of_day,
   output logic [47:0] rsp_zenith_rgb,
   output logic [47:0] rsp_horizon_rgb,
   output logic [47:0] rsp_light_rgb,
   output logic [47:0] rsp_light_direction_xyz,
   output logic [14:0] rsp_ambient_level,
   output logic [47:0] rsp_tint_rgb,

   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   // ---------------------------------------------------------------- sequencer
   kli_pkg::step_type      pc_ff, pc_in;
   kli_pkg::ctrl_word_type ctrl;
   logic                   branch_taken;

   // ---------------------------------------------------------------- datapath
   logic [15:0] day_speed_ff;
   logic [19:0] dt_ff;
   logic [35:0] prod_ff;
   logic [20:0] acc_ff;

   logic [kli_pkg::ROM_IDX_BITS-1:0] lo_ff, hi_ff;
   logic [20:0] d_ff, w_ff;       // offset into segment, segment width
   logic [21:0] rem_ff;           // divider remainder
   logic [16:0] q_ff;             // divider quotient
   logic [kli_pkg::DIV_CNT_BITS-1:0] cnt_ff;
   logic [16:0] t_ff;             // blend factor, Q1.16

   logic [kli_pkg::CHAN_IDX_BITS-1:0] chan_ff;
   logic signed [34:0] lprod_ff;
   logic [15:0] ch_ff [kli_pkg::CHANNELS];

   logic        rsp_valid_ff;
   logic        out_free;
   logic        emit_fire;

   // ------------------------------------------------- combinational helpers
   logic [21:0] sum;
   logic [20:0] acc_in;

   logic [kli_pkg::ROM_IDX_BITS-1:0] seg_lo, seg_hi;
   logic [20:0] seg_d, seg_w;

   logic        div_top;
   logic [21:0] rem_sh;
   logic        div_bit;

   logic signed [15:0] val_a, val_b;
   logic signed [16:0] diff;
   logic signed [17:0] t_ext;
   logic signed [34:0] lprod_in;
   logic [15:0]        lerp_res;

   assign req_ready = (pc_ff == kli_pkg::STEP_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // control word for the current step
   always_comb begin
      ctrl = kli_pkg::micro_word(pc_ff);
   end

   // next step
   always_comb begin
      case (ctrl.cond)
         kli_pkg::COND_NEVER:     branch_taken = 1'b0;
         kli_pkg::COND_NO_REQ:    branch_taken = !req_valid;
         kli_pkg::COND_DIV_MORE:  branch_taken = (cnt_ff != '1);
         kli_pkg::COND_CHAN_MORE: branch_taken = (chan_ff != '1);
         kli_pkg::COND_OUT_BUSY:  branch_taken = !out_free;
         default:                 branch_taken = 1'b0;
      endcase
      pc_in = branch_taken ? ctrl.branch : ctrl.next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= kli_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // time accumulate and wrap; inputs keep the sum below 48 h
   always_comb begin
      sum    = {1'b0, acc_ff} + {2'b00, prod_ff[35:16]};
      acc_in = (sum >= {1'b0, kli_pkg::HOURS_24}) ?
               21'(sum - {1'b0, kli_pkg::HOURS_24}) : sum[20:0];
   end

   // segment search: first segment with h_i <= time <= h_i+1; none -> last keyframe held
   always_comb begin
      seg_lo = kli_pkg::LAST_KEY;
      seg_hi = kli_pkg::LAST_KEY;
      seg_d  = '0;
      seg_w  = '0;
      for (int i = kli_pkg::KEYFRAME_COUNT - 2; i >= 0; i--) begin
         if (acc_ff >= kli_pkg::KF_HOUR[i] && acc_ff <= kli_pkg::KF_HOUR[i+1]) begin
            seg_lo = kli_pkg::ROM_IDX_BITS'(i);
            seg_hi = kli_pkg::ROM_IDX_BITS'(i + 1);
            seg_d  = acc_ff - kli_pkg::KF_HOUR[i];
            seg_w  = kli_pkg::KF_HOUR[i+1] - kli_pkg::KF_HOUR[i];
         end
      end
   end

   // restoring divider, one quotient bit per cycle
   always_comb begin
      div_top = (d_ff >= w_ff);
      rem_sh  = {rem_ff[20:0], 1'b0};
      div_bit = (rem_sh >= {1'b0, w_ff});
   end

   // channel lerp: a + floor((b - a) * t / 2^16), kept to 16 bits
   always_comb begin
      val_a    = kli_pkg::KF_VAL[lo_ff][chan_ff];
      val_b    = kli_pkg::KF_VAL[hi_ff][chan_ff];
      diff     = {val_b[15], val_b} - {val_a[15], val_a};
      t_ext    = {1'b0, t_ff};
      lprod_in = diff * t_ext;
      lerp_res = val_a + lprod_ff[31:16];
   end

   assign emit_fire = (ctrl.op == kli_pkg::OP_EMIT) && out_free;

   // config register and time of day
   always_ff @(posedge clock) begin
      if (reset) begin
         day_speed_ff <= kli_pkg::SPEED_RESET;
         acc_ff       <= kli_pkg::TIME_RESET;
      end else begin
         if (csr_wr_en) begin
            day_speed_ff <= csr_wr_data;
         end
         if (ctrl.op == kli_pkg::OP_ACC) begin
            acc_ff <= acc_in;
         end
      end
   end

   // datapath registers driven by the control word
   always_ff @(posedge clock) begin
      case (ctrl.op)
         kli_pkg::OP_LOAD: begin
            if (req_valid) begin
               dt_ff <= req_elapsed_time;
            end
         end
         kli_pkg::OP_MUL: begin
            prod_ff <= dt_ff * day_speed_ff;
         end
         kli_pkg::OP_ACC: begin
         end
         kli_pkg::OP_SEG: begin
            lo_ff <= seg_lo;
            hi_ff <= seg_hi;
            d_ff  <= seg_d;
            w_ff  <= seg_w;
         end
         kli_pkg::OP_DIV_INIT: begin
            rem_ff <= div_top ? {1'b0, d_ff - w_ff} : {1'b0, d_ff};
            q_ff   <= {16'b0, div_top};
            cnt_ff <= '0;
         end
         kli_pkg::OP_DIV_STEP: begin
            rem_ff <= div_bit ? rem_sh - {1'b0, w_ff} : rem_sh;
            q_ff   <= {q_ff[15:0], div_bit};
            cnt_ff <= cnt_ff + 1'b1;
         end
         kli_pkg::OP_T_FIX: begin
            t_ff    <= (w_ff == '0) ? '0 : q_ff;
            chan_ff <= '0;
         end
         kli_pkg::OP_LERP_MUL: begin
            lprod_ff <= lprod_in;
         end
         kli_pkg::OP_LERP_ADD: begin
            ch_ff[chan_ff] <= lerp_res;
            chan_ff        <= chan_ff + 1'b1;
         end
         kli_pkg::OP_EMIT: begin
            if (out_free) begin
               rsp_hour_of_day         <= acc_ff;
               rsp_zenith_rgb          <= kli_pkg::pack3(ch_ff[0], ch_ff[1], ch_ff[2]);
               rsp_horizon_rgb         <= kli_pkg::pack3(ch_ff[3], ch_ff[4], ch_ff[5]);
               rsp_light_rgb           <= kli_pkg::pack3(ch_ff[6], ch_ff[7], ch_ff[8]);
               rsp_light_direction_xyz <= kli_pkg::pack3(ch_ff[9], ch_ff[10], ch_ff[11]);
               rsp_ambient_level       <= ch_ff[12][14:0];
               rsp_tint_rgb            <= kli_pkg::pack3(ch_ff[13], ch_ff[14], ch_ff[15]);
            end
         end
         default: begin
         end
      endcase
   end

   // result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ---------------------------------------------------------------- checks
   a_time_below_24h: assert property (@(posedge clock) disable iff (reset)
      acc_ff < kli_pkg::HOURS_24)
      else $error("time of day reached 24 h");

   a_accept_starts_program: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (pc_ff == kli_pkg::STEP_MUL))
      else $error("accepted request did not start the program");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == kli_pkg::STEP_DIV && w_ff != '0) |-> (rem_ff < {1'b0, w_ff}))
      else $error("divider remainder not below segment width");

   a_t_range: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == kli_pkg::STEP_LERP_MUL) |-> (t_ff <= 17'h10000))
      else $error("blend factor above one");

endmodule
